// ===== sv/rsti_pkg.sv =====
// Shared types, constants and character helpers for the radix string-to-integer converter.
package rsti_pkg;

   localparam int VALUE_BITS_DEFAULT  = 32;
   localparam int OFFSET_BITS_DEFAULT = 16;

   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 8;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 6;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_SELECT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNED_MODE = 1'b1;

   localparam logic [RADIX_BITS-1:0] RADIX_INFER   = 6'd0;
   localparam logic [RADIX_BITS-1:0] RADIX_OCTAL   = 6'd8;
   localparam logic [RADIX_BITS-1:0] RADIX_DECIMAL = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_HEX     = 6'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
   localparam logic [RADIX_BITS-1:0] DIGIT_NONE    = 6'd63;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_CR      = 8'h0D;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SPACE,
      PH_PREFIX,
      PH_ZERO,
      PH_HEX,
      PH_DIGITS
   } phase_type;

   // Digit value of a character, or DIGIT_NONE when it is not alphanumeric.
   function automatic logic [RADIX_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] diff;
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         return diff[RADIX_BITS-1:0];
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         diff = c - CHAR_LOWER_A + 8'd10;
         return diff[RADIX_BITS-1:0];
      end
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         diff = c - CHAR_UPPER_A + 8'd10;
         return diff[RADIX_BITS-1:0];
      end
      return DIGIT_NONE;
   endfunction

   // Space, tab, newline, vertical tab, form feed and carriage return.
   function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

// ===== sv/radix_string_to_integer.sv =====
// Streaming string-to-integer converter with a two-word result buffer.
//
// Usage: bytes of a string arrive on the req_ channel, one word per byte,
// with req_first marking the first byte of a new string. Leading white
// space, one sign and, for base 0 or 16, a "0" or "0x" prefix are taken,
// then digits are accumulated. The first byte that is not a digit (NUL
// included) produces one result word on the rsp_ channel; bytes after it
// are dropped until the next byte marked first.
// Throughput is one byte per cycle while req_stall is low; each byte
// passes through one multiply-add of the running total by the radix
// (at most 6 bits wide). The result side holds an output register and
// one skid entry; a stop byte's result is registered in the output
// register if it is free, else in the skid entry, so bytes keep flowing
// while a result waits. req_stall rises only when both hold one not taken.
// The csr_ port writes base_select (index 0) and signed_mode (index 1) and
// is always ready; write it only while idle. base_select is sampled at the
// first byte, signed_mode when the result is formed.
// Reset (synchronous) empties the result buffer, returns the parser to
// idle and clears both registers.
module radix_string_to_integer #(
   parameter int VALUE_BITS  = rsti_pkg::VALUE_BITS_DEFAULT,
   parameter int OFFSET_BITS = rsti_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rsti_pkg::CHAR_BITS-1:0]      req_ch,
   input  logic                                req_first,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [VALUE_BITS-1:0]               rsp_value,
   output logic                                rsp_range_error,
   output logic                                rsp_converted,
   output logic [OFFSET_BITS-1:0]              rsp_end_offset,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsti_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rsti_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int RB        = rsti_pkg::RADIX_BITS;
   localparam int PROD_BITS = VALUE_BITS + RB;

   // Configuration registers.
   logic [RB-1:0] base_select_ff;
   logic          signed_mode_ff;

   // Parser state.
   rsti_pkg::phase_type    phase_ff,    phase_in;
   logic [VALUE_BITS-1:0]  total_ff,    total_in;
   logic                   negative_ff, negative_in;
   logic                   overflow_ff, overflow_in;
   logic                   any_digit_ff, any_digit_in;
   logic [RB-1:0]          radix_ff,    radix_in;
   logic [OFFSET_BITS-1:0] position_ff, position_in;

   // Result computed from the byte being accepted.
   logic                   emit;
   logic [OFFSET_BITS-1:0] emit_end;
   logic [VALUE_BITS-1:0]  res_value;
   logic                   res_error;
   logic [OFFSET_BITS-1:0] res_offset;

   logic [RB-1:0]          digit;
   logic [PROD_BITS-1:0]   product;
   logic [VALUE_BITS-1:0]  pos_limit;
   logic [VALUE_BITS-1:0]  neg_limit;

   // Output register and skid entry.
   logic                   out_valid_ff;
   logic [VALUE_BITS-1:0]  out_value_ff;
   logic                   out_error_ff;
   logic                   out_conv_ff;
   logic [OFFSET_BITS-1:0] out_offset_ff;
   logic                   skid_valid_ff;
   logic [VALUE_BITS-1:0]  skid_value_ff;
   logic                   skid_error_ff;
   logic                   skid_conv_ff;
   logic [OFFSET_BITS-1:0] skid_offset_ff;

   logic req_accept;
   logic out_take;
   logic out_free;
   logic new_result;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_take   = out_valid_ff && !rsp_stall;
   assign out_free   = !out_valid_ff || out_take;

   assign digit     = rsti_pkg::digit_of(req_ch);
   assign pos_limit = {1'b0, {(VALUE_BITS-1){1'b1}}};
   assign neg_limit = {1'b1, {(VALUE_BITS-1){1'b0}}};

   // The digit step needs the radix of this same byte, so the product is
   // formed from the radix the earlier phases settle on below.
   always_comb begin
      phase_in     = phase_ff;
      total_in     = total_ff;
      negative_in  = negative_ff;
      overflow_in  = overflow_ff;
      any_digit_in = any_digit_ff;
      radix_in     = radix_ff;
      position_in  = position_ff;
      emit         = 1'b0;
      emit_end     = '0;
      product      = '0;

      if (req_first) begin
         phase_in     = rsti_pkg::PH_SPACE;
         total_in     = '0;
         negative_in  = 1'b0;
         overflow_in  = 1'b0;
         any_digit_in = 1'b0;
         radix_in     = (base_select_ff > rsti_pkg::RADIX_MAX) ? rsti_pkg::RADIX_MAX
                                                               : base_select_ff;
         position_in  = '0;
      end

      if (phase_in == rsti_pkg::PH_SPACE) begin
         if (rsti_pkg::is_space(req_ch)) begin
            if (position_in != '1) position_in = position_in + 1'b1;
         end else if (req_ch == rsti_pkg::CHAR_MINUS || req_ch == rsti_pkg::CHAR_PLUS) begin
            negative_in = (req_ch == rsti_pkg::CHAR_MINUS);
            phase_in    = rsti_pkg::PH_PREFIX;
            if (position_in != '1) position_in = position_in + 1'b1;
         end else begin
            phase_in = rsti_pkg::PH_PREFIX;
            // Fall through to the prefix check with this same byte.
            if ((radix_in == rsti_pkg::RADIX_INFER || radix_in == rsti_pkg::RADIX_HEX)
                && req_ch == rsti_pkg::CHAR_ZERO) begin
               any_digit_in = 1'b1;
               if (radix_in == rsti_pkg::RADIX_INFER) radix_in = rsti_pkg::RADIX_OCTAL;
               phase_in = rsti_pkg::PH_ZERO;
               if (position_in != '1) position_in = position_in + 1'b1;
            end else begin
               if (radix_in == rsti_pkg::RADIX_INFER) radix_in = rsti_pkg::RADIX_DECIMAL;
               phase_in = rsti_pkg::PH_DIGITS;
            end
         end
      end else if (phase_in == rsti_pkg::PH_PREFIX) begin
         if ((radix_in == rsti_pkg::RADIX_INFER || radix_in == rsti_pkg::RADIX_HEX)
             && req_ch == rsti_pkg::CHAR_ZERO) begin
            any_digit_in = 1'b1;
            if (radix_in == rsti_pkg::RADIX_INFER) radix_in = rsti_pkg::RADIX_OCTAL;
            phase_in = rsti_pkg::PH_ZERO;
            if (position_in != '1) position_in = position_in + 1'b1;
         end else begin
            if (radix_in == rsti_pkg::RADIX_INFER) radix_in = rsti_pkg::RADIX_DECIMAL;
            phase_in = rsti_pkg::PH_DIGITS;
         end
      end else if (phase_in == rsti_pkg::PH_ZERO) begin
         if (req_ch == rsti_pkg::CHAR_LOWER_X || req_ch == rsti_pkg::CHAR_UPPER_X) begin
            radix_in = rsti_pkg::RADIX_HEX;
            phase_in = rsti_pkg::PH_HEX;
            if (position_in != '1) position_in = position_in + 1'b1;
         end else begin
            phase_in = rsti_pkg::PH_DIGITS;
         end
      end else if (phase_in == rsti_pkg::PH_HEX) begin
         // A bare "0x" reports the end just after the zero.
         if (digit >= rsti_pkg::RADIX_HEX) begin
            emit     = 1'b1;
            emit_end = (position_in != '0) ? position_in - 1'b1 : '0;
            phase_in = rsti_pkg::PH_IDLE;
         end else begin
            phase_in = rsti_pkg::PH_DIGITS;
         end
      end

      if (phase_in == rsti_pkg::PH_DIGITS && !(req_first == 1'b0 &&
          phase_ff == rsti_pkg::PH_IDLE)) begin
         if (digit < radix_in) begin
            product = PROD_BITS'(total_in) * PROD_BITS'(radix_in) + PROD_BITS'(digit);
            if (product[PROD_BITS-1:VALUE_BITS] != '0) overflow_in = 1'b1;
            total_in     = product[VALUE_BITS-1:0];
            any_digit_in = 1'b1;
            if (position_in != '1) position_in = position_in + 1'b1;
         end else begin
            emit     = 1'b1;
            emit_end = position_in;
            phase_in = rsti_pkg::PH_IDLE;
         end
      end
   end

   // Final value of a finished string.
   always_comb begin
      res_error = 1'b0;
      res_value = negative_in ? (VALUE_BITS'(0) - total_in) : total_in;
      if (signed_mode_ff) begin
         if (overflow_in || total_in > (negative_in ? neg_limit : pos_limit)) begin
            res_error = 1'b1;
            res_value = negative_in ? neg_limit : pos_limit;
         end
      end else if (overflow_in) begin
         res_error = 1'b1;
         res_value = '1;
      end
      res_offset = any_digit_in ? emit_end : '0;
   end

   assign new_result = req_accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_select_ff <= '0;
         signed_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rsti_pkg::CSR_BASE_SELECT: base_select_ff <= csr_data[RB-1:0];
            rsti_pkg::CSR_SIGNED_MODE: signed_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rsti_pkg::PH_IDLE;
         total_ff     <= '0;
         negative_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         any_digit_ff <= 1'b0;
         radix_ff     <= rsti_pkg::RADIX_DECIMAL;
         position_ff  <= '0;
      end else if (req_accept && (req_first || phase_ff != rsti_pkg::PH_IDLE)) begin
         phase_ff     <= phase_in;
         total_ff     <= total_in;
         negative_ff  <= negative_in;
         overflow_ff  <= overflow_in;
         any_digit_ff <= any_digit_in;
         radix_ff     <= radix_in;
         position_ff  <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= new_result;
            end
         end else if (new_result) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_value_ff  <= skid_value_ff;
            out_error_ff  <= skid_error_ff;
            out_conv_ff   <= skid_conv_ff;
            out_offset_ff <= skid_offset_ff;
         end else if (new_result) begin
            out_value_ff  <= res_value;
            out_error_ff  <= res_error;
            out_conv_ff   <= any_digit_in;
            out_offset_ff <= res_offset;
         end
      end else if (new_result) begin
         skid_value_ff  <= res_value;
         skid_error_ff  <= res_error;
         skid_conv_ff   <= any_digit_in;
         skid_offset_ff <= res_offset;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_range_error = out_error_ff;
   assign rsp_converted   = out_conv_ff;
   assign rsp_end_offset  = out_offset_ff;

`ifndef SYNTHESIS
   // The skid entry only fills behind a waiting output word.
   skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a word while the output register is empty");

   // A range error needs at least one accepted digit.
   error_needs_digit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_error_ff |-> out_conv_ff)
      else $error("range error reported without any converted digit");

   // Nothing converted means a zero value at offset zero.
   empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_conv_ff |-> (out_value_ff == '0) && (out_offset_ff == '0))
      else $error("empty conversion reported a nonzero value or offset");

   // The digit phase always runs with a settled, nonzero radix.
   digit_radix_set: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rsti_pkg::PH_DIGITS |-> radix_ff != rsti_pkg::RADIX_INFER)
      else $error("digit phase entered with the radix still to be inferred");

   // A word held in the output register is not lost while stalled.
   stalled_word_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_value_ff))
      else $error("stalled result word dropped or changed");
`endif

endmodule

// ===== verif/radix_string_to_integer_tb.sv =====
// Self-checking testbench for the streaming radix string-to-integer converter.
`timescale 1ns / 1ps

module radix_string_to_integer_tb;

   localparam int VALUE_BITS = 32;
   localparam int OFFSET_BITS = 16;
   localparam int CHAR_WIDTH = rsti_pkg::CHAR_BITS;
   localparam longint unsigned VALUE_MASK = (64'd1 << VALUE_BITS) - 1;
   localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_BITS) - 1;
   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [CHAR_WIDTH-1:0] ch;
      logic first;
   } string_byte_type;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic range_error;
      logic converted;
      logic [OFFSET_BITS-1:0] end_offset;
   } conversion_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CHAR_WIDTH-1:0] req_ch = '0;
   logic req_first = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_value;
   logic rsp_range_error;
   logic rsp_converted;
   logic [OFFSET_BITS-1:0] rsp_end_offset;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rsti_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [rsti_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   string_byte_type pending_bytes[$];
   conversion_type expected_conversions[$];

   // Register copies and parser state of the predictor.
   logic [rsti_pkg::RADIX_BITS-1:0] base_setting = rsti_pkg::RADIX_INFER;
   logic signed_setting = 1'b0;
   rsti_pkg::phase_type scan_phase = rsti_pkg::PH_IDLE;
   longint unsigned total = 0;
   bit is_negative = 0;
   bit overflow_seen = 0;
   bit digit_seen = 0;
   int unsigned radix = 32'(rsti_pkg::RADIX_DECIMAL);
   longint unsigned position = 0;

   bit mark_first = 1'b0;
   int unsigned bytes_pushed = 0;
   int unsigned bytes_taken = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 0;
   int unsigned failures = 0;
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit hold_armed = 0;
   bit hold_done = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   radix_string_to_integer #(
      .VALUE_BITS(VALUE_BITS),
      .OFFSET_BITS(OFFSET_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_ch(req_ch),
      .req_first(req_first),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_range_error(rsp_range_error),
      .rsp_converted(rsp_converted),
      .rsp_end_offset(rsp_end_offset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned digit_value(input logic [CHAR_WIDTH-1:0] c);
      if (c >= rsti_pkg::CHAR_ZERO && c <= rsti_pkg::CHAR_NINE)
         return 32'(c - rsti_pkg::CHAR_ZERO);
      if (c >= rsti_pkg::CHAR_LOWER_A && c <= rsti_pkg::CHAR_LOWER_Z)
         return 32'(c - rsti_pkg::CHAR_LOWER_A + 8'd10);
      if (c >= rsti_pkg::CHAR_UPPER_A && c <= rsti_pkg::CHAR_UPPER_Z)
         return 32'(c - rsti_pkg::CHAR_UPPER_A + 8'd10);
      return 32'(rsti_pkg::DIGIT_NONE);
   endfunction

   function automatic void step_position();
      if (position < OFFSET_MAX) position++;
   endfunction

   function automatic void close_string(input longint unsigned stop_at);
      conversion_type conv;
      longint unsigned top;
      longint unsigned limit;
      top = VALUE_MASK >> 1;
      conv.range_error = 1'b0;
      if (signed_setting) begin
         // The clamp value equals the limit: the most negative value when negative.
         limit = is_negative ? top + 1 : top;
         if (overflow_seen || total > limit) begin
            conv.range_error = 1'b1;
            conv.value = VALUE_BITS'(limit);
         end else begin
            conv.value = VALUE_BITS'(is_negative ? 64'd0 - total : total);
         end
      end else if (overflow_seen) begin
         conv.range_error = 1'b1;
         conv.value = VALUE_BITS'(VALUE_MASK);
      end else begin
         conv.value = VALUE_BITS'(is_negative ? 64'd0 - total : total);
      end
      conv.converted = digit_seen;
      conv.end_offset = digit_seen ? OFFSET_BITS'(stop_at) : '0;
      expected_conversions.push_back(conv);
      scan_phase = rsti_pkg::PH_IDLE;
   endfunction

   function automatic void predict_byte(input logic [CHAR_WIDTH-1:0] c, input logic start);
      int unsigned d;
      longint unsigned product;
      if (start) begin
         scan_phase = rsti_pkg::PH_SPACE;
         total = 0;
         is_negative = 0;
         overflow_seen = 0;
         digit_seen = 0;
         radix = 32'(base_setting > rsti_pkg::RADIX_MAX ? rsti_pkg::RADIX_MAX : base_setting);
         position = 0;
      end else if (scan_phase == rsti_pkg::PH_IDLE) begin
         return;
      end
      if (scan_phase == rsti_pkg::PH_SPACE) begin
         if (c == rsti_pkg::CHAR_SPACE || (c >= rsti_pkg::CHAR_TAB && c <= rsti_pkg::CHAR_CR))
         begin
            step_position();
            return;
         end
         scan_phase = rsti_pkg::PH_PREFIX;
         if (c == rsti_pkg::CHAR_MINUS || c == rsti_pkg::CHAR_PLUS) begin
            is_negative = (c == rsti_pkg::CHAR_MINUS);
            step_position();
            return;
         end
      end
      if (scan_phase == rsti_pkg::PH_PREFIX) begin
         if ((radix == rsti_pkg::RADIX_INFER || radix == rsti_pkg::RADIX_HEX) &&
             c == rsti_pkg::CHAR_ZERO) begin
            digit_seen = 1;
            if (radix == rsti_pkg::RADIX_INFER) radix = 32'(rsti_pkg::RADIX_OCTAL);
            scan_phase = rsti_pkg::PH_ZERO;
            step_position();
            return;
         end
         if (radix == rsti_pkg::RADIX_INFER) radix = 32'(rsti_pkg::RADIX_DECIMAL);
         scan_phase = rsti_pkg::PH_DIGITS;
      end
      if (scan_phase == rsti_pkg::PH_ZERO) begin
         if (c == rsti_pkg::CHAR_LOWER_X || c == rsti_pkg::CHAR_UPPER_X) begin
            radix = 32'(rsti_pkg::RADIX_HEX);
            scan_phase = rsti_pkg::PH_HEX;
            step_position();
            return;
         end
         scan_phase = rsti_pkg::PH_DIGITS;
      end
      if (scan_phase == rsti_pkg::PH_HEX) begin
         // A bare "0x" stops at the 'x' and reports the offset of the '0' plus one.
         if (digit_value(c) >= rsti_pkg::RADIX_HEX) begin
            close_string(position > 0 ? position - 1 : 0);
            return;
         end
         scan_phase = rsti_pkg::PH_DIGITS;
      end
      d = digit_value(c);
      if (d < radix) begin
         product = total * radix + d;
         if (product > VALUE_MASK) overflow_seen = 1;
         total = product & VALUE_MASK;
         digit_seen = 1;
         step_position();
         return;
      end
      close_string(position);
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endfunction

   // Sender: a word is taken at an edge with valid high and stall low.
   always @(posedge clock) begin
      string_byte_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_byte(req_ch, req_first);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               next_byte = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_ch <= next_byte.ch;
               req_first <= next_byte.first;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compares each result word and decides the next stall.
   always @(posedge clock) begin
      conversion_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_conversions.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, expected none, got value 0x%0h offset %0d",
                        $time, rsp_value, rsp_end_offset);
            end else begin
               want = expected_conversions.pop_front();
               check_field("value", 64'(want.value), 64'(rsp_value));
               check_field("range_error", 64'(want.range_error), 64'(rsp_range_error));
               check_field("converted", 64'(want.converted), 64'(rsp_converted));
               check_field("end_offset", 64'(want.end_offset), 64'(rsp_end_offset));
            end
         end
         if (hold_armed && !hold_done) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("radix_string_to_integer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void add_byte(input logic [CHAR_WIDTH-1:0] c);
      string_byte_type b;
      b.ch = c;
      b.first = mark_first;
      mark_first = 1'b0;
      pending_bytes.push_back(b);
      bytes_pushed++;
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input int unsigned d);
      if (d < 10) return rsti_pkg::CHAR_ZERO + CHAR_WIDTH'(d);
      return ($urandom_range(0, 1) ? rsti_pkg::CHAR_LOWER_A : rsti_pkg::CHAR_UPPER_A) +
             CHAR_WIDTH'(d - 10);
   endfunction

   function automatic void add_random_string();
      int unsigned kind;
      int unsigned pick;
      int unsigned r;
      longint unsigned num;
      logic [CHAR_WIDTH-1:0] digits[$];
      mark_first = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 6)) add_byte(CHAR_WIDTH'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3))
            add_byte($urandom_range(0, 5) == 0 ? rsti_pkg::CHAR_SPACE
                     : rsti_pkg::CHAR_TAB + CHAR_WIDTH'($urandom_range(0, 4)));
      pick = $urandom_range(0, 3);
      if (pick == 1) add_byte(rsti_pkg::CHAR_PLUS);
      if (pick == 2) add_byte(rsti_pkg::CHAR_MINUS);
      r = 32'(base_setting > rsti_pkg::RADIX_MAX ? rsti_pkg::RADIX_MAX : base_setting);
      if (r == rsti_pkg::RADIX_INFER || r == rsti_pkg::RADIX_HEX) begin
         pick = $urandom_range(0, 3);
         if (pick >= 1) add_byte(rsti_pkg::CHAR_ZERO);
         if (pick >= 2) add_byte(pick == 2 ? rsti_pkg::CHAR_LOWER_X : rsti_pkg::CHAR_UPPER_X);
         if (r == rsti_pkg::RADIX_INFER)
            r = pick >= 2 ? 32'(rsti_pkg::RADIX_HEX)
                : (pick == 1 ? 32'(rsti_pkg::RADIX_OCTAL) : 32'(rsti_pkg::RADIX_DECIMAL));
      end
      if (kind < 25 && r >= 2) begin
         // Values around the signed and unsigned limits, near zero or random, written in the radix.
         case ($urandom_range(0, 5))
            0: num = (VALUE_MASK >> 1) - 1 + 64'($urandom_range(0, 2));
            1: num = VALUE_MASK - 1 + 64'($urandom_range(0, 2));
            2: num = 64'($urandom_range(0, 2));
            3: num = {$urandom, $urandom} >> $urandom_range(0, 40);
            default: num = 64'($urandom);
         endcase
         do begin
            digits.push_front(digit_char(32'(num % r)));
            num = num / r;
         end while (num != 0);
      end else begin
         repeat ($urandom_range(0, kind < 35 ? 40 : 10))
            digits.push_back(digit_char($urandom_range(0, r == 0 ? 0 : r - 1)));
      end
      foreach (digits[i]) add_byte(digits[i]);
      // Some strings are cut short and restarted by the next first word.
      if (kind >= 25 && kind < 31) return;
      case ($urandom_range(0, 2))
         0: add_byte(8'h00);
         1: add_byte(CHAR_WIDTH'($urandom_range(0, 255)));
         default: add_byte(CHAR_WIDTH'($urandom_range(128, 255)));
      endcase
      if ($urandom_range(0, 6) == 0)
         repeat ($urandom_range(1, 3)) add_byte(CHAR_WIDTH'($urandom_range(0, 255)));
   endfunction

   function automatic void add_random_strings(input int unsigned count);
      int unsigned stop_at;
      stop_at = bytes_pushed + count;
      while (bytes_pushed < stop_at) add_random_string();
      // A trailing NUL closes any open string so the next register write finds the block idle.
      mark_first = 1'b0;
      add_byte(8'h00);
   endfunction

   task automatic wait_until_quiet();
      while (bytes_taken != bytes_pushed || expected_conversions.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [rsti_pkg::CSR_INDEX_BITS-1:0] reg_index,
                                 input logic [rsti_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (reg_index == rsti_pkg::CSR_BASE_SELECT) base_setting = data;
      else signed_setting = data[0];
   endtask

   task automatic configure(input logic [rsti_pkg::RADIX_BITS-1:0] base,
                            input logic signed_conv);
      wait_until_quiet();
      write_register(rsti_pkg::CSR_BASE_SELECT, base);
      write_register(rsti_pkg::CSR_SIGNED_MODE,
                     {{(rsti_pkg::CSR_DATA_BITS-1){1'b0}}, signed_conv});
      settings_used++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 35;
      recv_stall_pct = 86;
      configure(rsti_pkg::RADIX_INFER, 1'b0);
      // A stray word before any string start is dropped.
      mark_first = 1'b0;
      add_byte(rsti_pkg::CHAR_ZERO + 8'd7);
      mark_first = 1'b1;
      add_text(" -0x1F");
      add_byte(8'h00);
      mark_first = 1'b1;
      add_text("0xg");
      mark_first = 1'b1;
      add_text("+");
      add_byte(8'h00);
      mark_first = 1'b1;
      add_byte(rsti_pkg::CHAR_ZERO);
      add_byte(8'hFF);
      add_byte(rsti_pkg::CHAR_LOWER_X);
      configure(rsti_pkg::RADIX_MAX, 1'b1);
      mark_first = 1'b1;
      add_text("zZzZzZz");
      add_byte(8'h00);

      configure(rsti_pkg::RADIX_INFER, 1'b1);
      add_random_strings(170);
      configure(rsti_pkg::RADIX_DECIMAL, 1'b0);
      add_random_strings(170);
      configure(rsti_pkg::RADIX_HEX, 1'b1);
      add_random_strings(170);

      send_gap_pct = 86;
      recv_stall_pct = 35;
      configure(6'd2, 1'b0);
      add_random_strings(150);
      configure(6'd63, 1'b1);
      add_random_strings(150);
      configure(6'd1, 1'b0);
      add_random_strings(130);

      send_gap_pct = 0;
      recv_stall_pct = 0;
      configure(rsti_pkg::RADIX_OCTAL, 1'b1);
      add_random_strings(120);
      configure(rsti_pkg::RADIX_MAX, 1'b0);
      // The receiver holds off while words keep coming, so the input backs up.
      hold_armed = 1;
      add_random_strings(120);
      configure(rsti_pkg::RADIX_INFER, 1'b0);
      add_random_strings(120);

      wait_until_quiet();
      repeat (20) @(posedge clock);
      $display("Checked %0d conversions from %0d bytes under %0d register settings,",
               results_checked, bytes_taken, settings_used);
      $display("with random gaps on both sides and a %0d-cycle output hold.", HOLD_CYCLES);
      if (failures == 0 && expected_conversions.size() == 0) begin
         $display("radix_string_to_integer regression: pass");
      end else begin
         $display("%0d failures, %0d results never arrived", failures,
                  expected_conversions.size());
         $display("radix_string_to_integer regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/rsti_pkg.sv
sv/radix_string_to_integer.sv
verif/radix_string_to_integer_tb.sv
